>>> hdl/btb_pkg.sv
package btb_pkg;

  localparam int MAX_NODES = 1024;
  localparam int SIZE_W = 11;
  localparam int OP_W = 3;
  localparam int IDX_W = 10;
  localparam int LVL_W = 4;
  localparam int WORD_W = 32;
  localparam int OFF_W = $clog2(WORD_W);
  localparam int ROWS = (MAX_NODES + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W = SIZE_W + 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int REG_BITS_IN_USE = 0;

  localparam logic [SIZE_W-1:0] BITS_IN_USE_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_NODES);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_MARK     = 3'd2,
    OP_ANCESTOR = 3'd3,
    OP_SUBTREE  = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_EMPTY    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             val;
    logic             err;
  } cmd_t;

  typedef struct packed {
    logic             read_bit;
    logic [LVL_W-1:0] level;
    logic             subtree_free;
    logic             store_empty;
    logic             index_error;
  } res_t;

  function automatic logic [WORD_W-1:0] range_mask(input logic [OFF_W:0] lo,
                                                   input logic [OFF_W:0] hi);
    logic [WORD_W-1:0] m;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((OFF_W+1)'(b) >= lo) && ((OFF_W+1)'(b) < hi);
    end
    return m;
  endfunction

endpackage

>>> hdl/btb_ram.sv
module btb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/btb_front.sv
module btb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [btb_pkg::OP_W-1:0]     operation_i,
  input  logic [btb_pkg::IDX_W-1:0]    node_index_i,
  input  logic                         bit_value_i,
  input  logic [btb_pkg::SIZE_W-1:0]   size_i,
  output logic                         cmd_valid_o,
  output btb_pkg::cmd_t                cmd_o,
  input  logic                         cmd_pop_i
);
  import btb_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push;
  cmd_t              cls;

  always_comb begin
    cls.op  = op_e'(operation_i);
    cls.idx = node_index_i;
    cls.val = bit_value_i;
    cls.err = (operation_i <= OP_SUBTREE) &&
              ((node_index_i == '0) || (SIZE_W'(node_index_i) >= size_i));
  end

  assign in_stall_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> hdl/btb_back.sv
module btb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [btb_pkg::SIZE_W-1:0] size_i,
  input  logic                       cmd_valid_i,
  input  btb_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output btb_pkg::res_t              res_o
);
  import btb_pkg::*;

  function automatic logic [POS_W-1:0] min_pos(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  first_q, first_d;
  logic [POS_W-1:0]  span_q, span_d;
  logic [POS_W-1:0]  lim_q, lim_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              val_q, val_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [ROWS-1:0]   valid_q, valid_d;
  logic              rd_valid_q, rd_valid_d;

  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [ROW_W-1:0]  row;
  logic [POS_W-1:0]  rowbase, row_end, n_pos, buddy, sub_hi, sub_nxt, emp_hi;
  logic [OFF_W-1:0]  off;
  logic [OFF_W:0]    emp_lo;
  logic [WORD_W-1:0] word, sub_mask, emp_mask, bit_sel;
  logic              mark_cont, sub_hit, emp_hit, scan_end, ev_last, start_out, out_free;

  btb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    row       = pos_q[OFF_W +: ROW_W];
    rowbase   = {pos_q[POS_W-1:OFF_W], {OFF_W{1'b0}}};
    row_end   = rowbase + POS_W'(WORD_W);
    n_pos     = POS_W'(size_i);
    off       = pos_q[OFF_W-1:0];
    word      = rd_valid_q ? ram_rdata : '0;
    bit_sel   = WORD_W'(1) << off;
    buddy     = pos_q ^ POS_W'(1);
    mark_cont = (pos_q > POS_W'(1)) && (buddy < n_pos) && word[buddy[OFF_W-1:0]];
    sub_hi    = min_pos(min_pos(lim_q, n_pos), row_end);
    sub_nxt   = min_pos(lim_q, row_end);
    sub_mask  = range_mask({1'b0, off}, (OFF_W+1)'(sub_hi - rowbase));
    sub_hit   = |(word & sub_mask);
    emp_hi    = min_pos(n_pos, row_end);
    emp_lo    = (rowbase == '0) ? (OFF_W+1)'(1) : '0;
    emp_mask  = range_mask(emp_lo, (OFF_W+1)'(emp_hi - rowbase));
    emp_hit   = |(word & emp_mask);
    scan_end  = (pos_q >= n_pos);
    out_free  = !out_valid_q || !out_stall_i;

    case (op_q)
      OP_MARK:     ev_last = !mark_cont;
      OP_ANCESTOR: ev_last = (pos_q == POS_W'(1));
      OP_SUBTREE:  ev_last = sub_hit;
      OP_EMPTY:    ev_last = emp_hit;
      default:     ev_last = 1'b1;
    endcase

    case (cmd_i.op)
      OP_WRITE, OP_READ, OP_MARK, OP_SUBTREE: start_out = cmd_i.err;
      OP_ANCESTOR: start_out = cmd_i.err || (cmd_i.idx == IDX_W'(1));
      OP_CLEAR:    start_out = (size_i[OFF_W-1:0] == '0);
      OP_EMPTY:    start_out = 1'b0;
      default:     start_out = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = start_out ? ST_OUT : ST_RD;
        end
      end
      ST_RD: begin
        if ((op_q inside {OP_SUBTREE, OP_EMPTY}) && scan_end) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_EV;
        end
      end
      ST_EV: begin
        state_d = ev_last ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    pos_d       = pos_q;
    first_d     = first_q;
    span_d      = span_q;
    lim_d       = lim_q;
    lvl_d       = lvl_q;
    val_d       = val_q;
    res_d       = res_q;
    out_d       = out_q;
    valid_d     = valid_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = word;
    cmd_pop_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o         = 1'b1;
          op_d              = cmd_i.op;
          val_d             = cmd_i.val;
          res_d             = '0;
          res_d.index_error = cmd_i.err;
          pos_d             = POS_W'(cmd_i.idx);
          lvl_d             = LVL_W'(1);
          case (cmd_i.op)
            OP_ANCESTOR: pos_d = POS_W'(cmd_i.idx >> 1);
            OP_SUBTREE: begin
              first_d = POS_W'(cmd_i.idx) << 1;
              span_d  = POS_W'(2);
              pos_d   = POS_W'(cmd_i.idx) << 1;
              lim_d   = (POS_W'(cmd_i.idx) << 1) + POS_W'(2);
            end
            OP_CLEAR: begin
              pos_d = POS_W'(size_i);
              for (int r = 0; r < ROWS; r++) begin
                if ((r + 1) * WORD_W <= int'(size_i)) begin
                  valid_d[r] = 1'b0;
                end
              end
            end
            OP_EMPTY: pos_d = '0;
            default: ;
          endcase
        end
      end
      ST_RD: begin
        if ((op_q inside {OP_SUBTREE, OP_EMPTY}) && scan_end) begin
          if (op_q == OP_SUBTREE) begin
            res_d.subtree_free = 1'b1;
          end else begin
            res_d.store_empty = 1'b1;
          end
        end else begin
          ram_re     = 1'b1;
          rd_valid_d = valid_q[row];
        end
      end
      ST_EV: begin
        case (op_q)
          OP_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = val_q ? (word | bit_sel) : (word & ~bit_sel);
          end
          OP_READ: res_d.read_bit = word[off];
          OP_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = word | bit_sel;
            pos_d     = pos_q >> 1;
          end
          OP_ANCESTOR: begin
            if (word[off]) begin
              res_d.level = lvl_q;
            end
            pos_d = pos_q >> 1;
            lvl_d = lvl_q + LVL_W'(1);
          end
          OP_SUBTREE: begin
            if (sub_nxt == lim_q) begin
              first_d = first_q << 1;
              span_d  = span_q << 1;
              pos_d   = first_q << 1;
              lim_d   = (first_q << 1) + (span_q << 1);
            end else begin
              pos_d = sub_nxt;
            end
          end
          OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = word & ~range_mask('0, {1'b0, size_i[OFF_W-1:0]});
          end
          OP_EMPTY: pos_d = row_end;
          default: ;
        endcase
        if (ram_we) begin
          valid_d[row] = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      rd_valid_q  <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    first_q <= first_d;
    span_q  <= span_d;
    lim_q   <= lim_d;
    lvl_q   <= lvl_d;
    val_q   <= val_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE) && cmd_valid_i)
    else $error("command popped outside idle");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.index_error |-> !out_q.read_bit && (out_q.level == '0) &&
      !out_q.subtree_free && !out_q.store_empty)
    else $error("index error result carries data");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.read_bit, out_q.subtree_free, out_q.store_empty,
                              out_q.index_error}))
    else $error("more than one result flag set");

  a_write_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == ST_OUT) || (state_q == ST_RD))
    else $error("store write not followed by read or result");

endmodule

>>> hdl/buddy_tree_bitmap.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    operation_i, node_index_i, bit_value_i
// out      output     out_valid_o / out_stall_i  read_bit_o, ancestor_level_o,
//                                                subtree_free_o, store_empty_o, index_error_o
// config   input      APB psel/penable/pwrite    bits_in_use at byte address 0
//
// Each request passes through a read state and an evaluate state for every access to the
// 32-bit-wide node store, whose registered read and write share one row address and set the
// pace: write and read make one access, clear at most one, mark used one per level climbed,
// the ancestor check one per level to the root, subtree and empty checks one per word visited.
// Reset sets bits_in_use to 1024 and clears one valid flag per store word, so the store
// reads as all clear at once. A two-entry queue accepts requests, until it is full, while the back
// end works or a result waits on out_stall_i.
module buddy_tree_bitmap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [btb_pkg::OP_W-1:0]     operation_i,
  input  logic [btb_pkg::IDX_W-1:0]    node_index_i,
  input  logic                         bit_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         read_bit_o,
  output logic [btb_pkg::LVL_W-1:0]    ancestor_level_o,
  output logic                         subtree_free_o,
  output logic                         store_empty_o,
  output logic                         index_error_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import btb_pkg::*;

  logic [SIZE_W-1:0] bits_in_use_q, bits_in_use_d;
  logic [SIZE_W-1:0] size_eff;
  logic              cfg_we;
  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;
  res_t              res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'(REG_BITS_IN_USE));
  assign prdata = (paddr[2] == 1'(REG_BITS_IN_USE)) ? 32'(bits_in_use_q) : '0;

  always_comb begin
    bits_in_use_d = cfg_we ? pwdata[SIZE_W-1:0] : bits_in_use_q;
    size_eff      = (bits_in_use_q > SIZE_CAP) ? SIZE_CAP : bits_in_use_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= BITS_IN_USE_RESET;
    end else begin
      bits_in_use_q <= bits_in_use_d;
    end
  end

  btb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .node_index_i (node_index_i),
    .bit_value_i  (bit_value_i),
    .size_i       (size_eff),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  btb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign read_bit_o       = res.read_bit;
  assign ancestor_level_o = res.level;
  assign subtree_free_o   = res.subtree_free;
  assign store_empty_o    = res.store_empty;
  assign index_error_o    = res.index_error;

endmodule
